// ===== rtl/lfpa_pkg.sv =====
package lfpa_pkg;

	// Fixed field widths
	localparam int PERIOD_BITS = 8;
	localparam int FRAC_BITS   = 16;
	localparam int LEVEL_W     = 8;
	localparam int STEP_W      = 25;
	localparam int MODE_W      = 2;
	localparam int COUNT_W     = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 3;

	// Intensity must hold the largest limit plus one step without wrapping
	localparam int INT_W   = (((LEVEL_W + FRAC_BITS) > STEP_W) ?
		(LEVEL_W + FRAC_BITS) : STEP_W) + 1;
	localparam int IPART_W = INT_W - FRAC_BITS;
	localparam int CMP_W   = (IPART_W > PERIOD_BITS) ? IPART_W : PERIOD_BITS;

	localparam logic [COUNT_W-1:0] FOREVER   = {COUNT_W{1'b1}};
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

	// Fade modes
	localparam logic [MODE_W-1:0] FADE_IN   = 2'd0;
	localparam logic [MODE_W-1:0] FADE_OUT  = 2'd1;
	localparam logic [MODE_W-1:0] PING_PONG = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_MODE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LENGTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TOTAL = 3'd6;

	typedef struct packed {
		logic [LEVEL_W-1:0] min_level;
		logic [LEVEL_W-1:0] max_level;
		logic [STEP_W-1:0]  ramp_step;
		logic [MODE_W-1:0]  fade_mode;
		logic [COUNT_W-1:0] hold_length;
	} anim_cfg_t;

	typedef struct packed {
		logic [INT_W-1:0]   intensity;
		logic               going_up;
		logic [COUNT_W-1:0] hold_left;
		logic [COUNT_W-1:0] repeats_left;
	} anim_state_t;

endpackage

// ===== rtl/led_fade_pwm_animator_unit.sv =====
// LED fade / breathing PWM animator.
//
// Input channel (in_valid / in_stall, payload tick): each request is one PWM
// tick. tick = 1 advances the period counter; when it wraps the fade
// animation takes one step. tick = 0 only samples the current outputs.
// Output channel (out_valid / out_stall): one result per request carrying
// led_level, level_now, period_end and finished, computed from the state
// after that request's update.
// Pipeline: a request accepted sits in the input register; when the result
// register is free, the state update runs into the result register, which
// drives out_valid. Throughput is one request per cycle while the receiver
// does not stall, set by the combinational add/compare of the animation
// step.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; after that in_stall rises until the result
// is taken.
// Configuration (cfg_we, cfg_index, cfg_data) writes one register per edge;
// any write to a listed register reloads intensity, direction, hold and
// repeat count. Write only while no request is in flight.
// Reset (arst_n low) loads the default registers and the start state; no
// clearing pass is needed.
module led_fade_pwm_animator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                tick,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                led_level,
	output logic [lfpa_pkg::LEVEL_W-1:0]        level_now,
	output logic                                period_end,
	output logic                                finished,
	input  logic                                cfg_we,
	input  logic [lfpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lfpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lfpa_pkg::*;

	// configuration registers
	anim_cfg_t          cfg_q, cfg_n;
	logic [LEVEL_W-1:0] start_level_q, start_level_n, start_clamped;
	logic [COUNT_W-1:0] repeat_total_q, repeat_total_n;
	logic               cfg_hit;

	// animation state
	logic [PERIOD_BITS-1:0] pc_q, pc_next;
	anim_state_t            st_q, st_next;
	logic                   wrap;

	// pipeline
	logic valid_s1, tick_s1;
	logic valid_s2;
	logic led_level_s2, period_end_s2, finished_s2;
	logic [LEVEL_W-1:0] level_now_s2;
	logic advance, in_take;

	logic [IPART_W-1:0] ipart;

	// Register write decode: next register values, used both for storage and
	// for the reload that every valid write triggers.
	always_comb begin
		cfg_n          = cfg_q;
		start_level_n  = start_level_q;
		repeat_total_n = repeat_total_q;
		cfg_hit        = cfg_we;
		unique case (cfg_index)
			REG_MIN_LEVEL:    cfg_n.min_level   = cfg_data[LEVEL_W-1:0];
			REG_MAX_LEVEL:    cfg_n.max_level   = cfg_data[LEVEL_W-1:0];
			REG_START_LEVEL:  start_level_n     = cfg_data[LEVEL_W-1:0];
			REG_RAMP_STEP:    cfg_n.ramp_step   = cfg_data[STEP_W-1:0];
			REG_FADE_MODE:    cfg_n.fade_mode   = cfg_data[MODE_W-1:0];
			REG_HOLD_LENGTH:  cfg_n.hold_length = cfg_data[COUNT_W-1:0];
			REG_REPEAT_TOTAL: repeat_total_n    = cfg_data[COUNT_W-1:0];
			default:          cfg_hit           = 1'b0;
		endcase
	end

	// start clamp: below min wins over above max
	assign start_clamped = (start_level_n < cfg_n.min_level) ? cfg_n.min_level :
		(start_level_n > cfg_n.max_level) ? cfg_n.max_level : start_level_n;

	// handshake: output register frees when empty or taken
	assign advance  = ~valid_s2 | ~out_stall;
	assign in_stall = valid_s1 & ~advance;
	assign in_take  = in_valid & ~in_stall;

	// period counter and wrap detect for the request in stage 1
	assign pc_next = tick_s1 ? pc_q + 1'b1 : pc_q;
	assign wrap    = tick_s1 && (pc_next == '0);

	lfpa_step u_step (
		.cfg  (cfg_q),
		.cur  (st_q),
		.wrap (wrap),
		.nxt  (st_next)
	);

	assign ipart = st_next.intensity[INT_W-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_level   <= '0;
			cfg_q.max_level   <= LEVEL_MAX;
			cfg_q.ramp_step   <= STEP_W'(1 << FRAC_BITS);
			cfg_q.fade_mode   <= PING_PONG;
			cfg_q.hold_length <= '0;
			start_level_q     <= '0;
			repeat_total_q    <= FOREVER;
			pc_q              <= '0;
			st_q.intensity    <= '0;
			st_q.going_up     <= 1'b1;
			st_q.hold_left    <= '0;
			st_q.repeats_left <= FOREVER;
			valid_s1          <= 1'b0;
			valid_s2          <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= valid_s1;

			if (cfg_hit) begin
				cfg_q             <= cfg_n;
				start_level_q     <= start_level_n;
				repeat_total_q    <= repeat_total_n;
				st_q.intensity    <= INT_W'({start_clamped, {FRAC_BITS{1'b0}}});
				st_q.going_up     <= 1'b1;
				st_q.hold_left    <= '0;
				st_q.repeats_left <= repeat_total_n;
			end else if (valid_s1 && advance) begin
				st_q <= st_next;
			end

			// period counter keeps running across register writes
			if (valid_s1 && advance)
				pc_q <= pc_next;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_take)
			tick_s1 <= tick;
		if (advance && valid_s1) begin
			led_level_s2  <= (CMP_W'(ipart) <= CMP_W'(pc_next));
			level_now_s2  <= (ipart > IPART_W'(LEVEL_MAX)) ? LEVEL_MAX :
				ipart[LEVEL_W-1:0];
			period_end_s2 <= wrap;
			finished_s2   <= (st_next.repeats_left == '0);
		end
	end

	assign out_valid  = valid_s2;
	assign led_level  = led_level_s2;
	assign level_now  = level_now_s2;
	assign period_end = period_end_s2;
	assign finished   = finished_s2;

	// stage 1 blocked by a stalled result must push back on the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |-> in_stall)
		else $error("stage 1 overrun while output stalled");

	// a wrap report always comes with the counter at zero
	a_wrap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && period_end_s2 |-> pc_q == '0)
		else $error("period_end without counter wrap");

	// register writes restart the animation
	a_reload_dir: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> st_q.going_up && st_q.hold_left == '0)
		else $error("reload did not restart direction and hold");

	// a new output only appears when stage 1 held a request
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 && !valid_s1 |=> !valid_s2)
		else $error("result appeared without a request");

endmodule

// ===== rtl/lfpa_step.sv =====
module lfpa_step (
	input  lfpa_pkg::anim_cfg_t   cfg,
	input  lfpa_pkg::anim_state_t cur,
	input  logic                  wrap,
	output lfpa_pkg::anim_state_t nxt
);
	import lfpa_pkg::*;

	logic [INT_W-1:0] lo, hi, step, sum, diff;
	logic             up, move, ended, close_cycle;

	assign lo   = INT_W'({cfg.min_level, {FRAC_BITS{1'b0}}});
	assign hi   = INT_W'({cfg.max_level, {FRAC_BITS{1'b0}}});
	assign step = INT_W'(cfg.ramp_step);
	assign sum  = cur.intensity + step;
	assign diff = cur.intensity - step;

	always_comb begin
		nxt         = cur;
		up          = 1'b1;
		move        = 1'b1;
		ended       = 1'b0;
		close_cycle = 1'b0;

		case (cfg.fade_mode)
			FADE_IN:   up = 1'b1;
			FADE_OUT:  up = 1'b0;
			PING_PONG: up = cur.going_up;
			default:   move = 1'b0;
		endcase

		if (wrap && cur.repeats_left != '0) begin
			if (cur.hold_left != '0) begin
				nxt.hold_left = cur.hold_left - 1'b1;
				if (cur.hold_left == COUNT_W'(1) && cur.repeats_left != FOREVER)
					nxt.repeats_left = cur.repeats_left - 1'b1;
			end else if (move) begin
				if (up) begin
					nxt.intensity = sum;
					ended = (sum > hi);
				end else if (cur.intensity < step) begin
					ended = 1'b1;
				end else begin
					nxt.intensity = diff;
					ended = (diff < step) || (diff < lo);
				end

				if (ended) begin
					case (cfg.fade_mode)
						FADE_IN: begin
							nxt.intensity = lo;
							close_cycle = 1'b1;
						end
						FADE_OUT: begin
							nxt.intensity = hi;
							close_cycle = 1'b1;
						end
						default: begin
							nxt.intensity = cur.going_up ? hi : lo;
							nxt.going_up  = ~cur.going_up;
							close_cycle   = cur.going_up;
						end
					endcase
				end

				if (close_cycle) begin
					if (cfg.hold_length != '0)
						nxt.hold_left = cfg.hold_length;
					else if (cur.repeats_left != FOREVER)
						nxt.repeats_left = cur.repeats_left - 1'b1;
				end
			end
		end
	end

endmodule
